// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL that checks its own logic (crb_ctrl includes them).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CRB_ASSERT(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Same-cycle implication, checked outside reset.
`define CRB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CRB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/crb_pkg.sv =====
// Package of types and constants for the chunk reorder buffer.
package crb_pkg;

    localparam int OFF_W   = 32;
    localparam int LEN_W   = 12;
    localparam int LEN_LSB = OFF_W;
    localparam int TAG_LSB = OFF_W + LEN_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FULL_CHK,
        S_SHIFT,
        S_PUT,
        S_REL_RD,
        S_REL_CHK,
        S_REL_END,
        S_DROP
    } t_state;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

endpackage

// ===== rtl/crb_table.sv =====
// Pending chunk table: one write port, one read port, registered read data.
module crb_table #(
    parameter int SLOTS = 17,
    parameter int AW    = 5,
    parameter int DW    = 52
) (
    input  logic               i_clk,
    input  crb_pkg::t_mem_ctl  i_ctl,
    input  logic [AW-1:0]      i_rd_addr,
    input  logic [AW-1:0]      i_wr_addr,
    input  logic [DW-1:0]      i_wr_data,
    output logic [DW-1:0]      o_rd_data
);

    logic [DW-1:0] mem [SLOTS];
    logic [DW-1:0] r_rd_data;

    // a read and a write to the same slot return the old contents
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/crb_ctrl.sv =====
// Sequencer for the chunk reorder buffer: insertion walk, release loop, result register.
`include "assert_macros.svh"

module crb_ctrl #(
    parameter int TABLE_DEPTH = 16,
    parameter int TAG_BITS    = 8,
    parameter int PW          = 5,
    parameter int EW          = 52
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [crb_pkg::OFF_W-1:0] i_chunk_offset,
    input  logic [crb_pkg::LEN_W-1:0] i_chunk_length,
    input  logic [TAG_BITS-1:0]       i_chunk_tag,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [crb_pkg::OFF_W-1:0] o_released_offset,
    output logic [crb_pkg::LEN_W-1:0] o_released_length,
    output logic [TAG_BITS-1:0]       o_released_tag,
    output logic                      o_dropped,
    output logic                      o_last,
    output crb_pkg::t_mem_ctl         o_mem_ctl,
    output logic [PW-1:0]             o_rd_addr,
    output logic [PW-1:0]             o_wr_addr,
    output logic [EW-1:0]             o_wr_data,
    input  logic [EW-1:0]             i_rd_data
);

    localparam int SLOTS = TABLE_DEPTH + 1;
    localparam int CW    = $clog2(TABLE_DEPTH + 2);

    crb_pkg::t_state r_state, n_state;

    logic [PW-1:0]             r_base, n_base;
    logic [CW-1:0]             r_cnt, n_cnt;
    logic [crb_pkg::OFF_W-1:0] r_pos, n_pos;
    logic [PW-1:0]             r_ptr, n_ptr;
    logic [PW-1:0]             r_left, n_left;

    logic [crb_pkg::OFF_W-1:0] r_off, n_off;
    logic [crb_pkg::LEN_W-1:0] r_len, n_len;
    logic [TAG_BITS-1:0]       r_tag, n_tag;

    logic                      r_cand_vld, n_cand_vld;
    logic [crb_pkg::OFF_W-1:0] r_cand_off, n_cand_off;
    logic [crb_pkg::LEN_W-1:0] r_cand_len, n_cand_len;
    logic [TAG_BITS-1:0]       r_cand_tag, n_cand_tag;

    logic                      r_out_vld, n_out_vld;
    logic [crb_pkg::OFF_W-1:0] r_out_off, n_out_off;
    logic [crb_pkg::LEN_W-1:0] r_out_len, n_out_len;
    logic [TAG_BITS-1:0]       r_out_tag, n_out_tag;
    logic                      r_out_drop, n_out_drop;
    logic                      r_out_last, n_out_last;

    logic [crb_pkg::OFF_W-1:0] rd_off;
    logic [crb_pkg::LEN_W-1:0] rd_len;
    logic [EW-1:0]             new_entry;
    logic [PW-1:0]             tail;
    logic [PW-1:0]             last_slot;
    logic                      out_free;
    logic                      head_match;
    logic                      full_drop;
    logic                      shift_up;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(SLOTS - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
        return (p == '0) ? PW'(SLOTS - 1) : p - 1'b1;
    endfunction

    function automatic logic [PW-1:0] ptr_add(input logic [PW-1:0] p, input logic [CW-1:0] c);
        logic [PW:0] s;
        s = {1'b0, p} + (PW + 1)'(c);
        if (s >= (PW + 1)'(SLOTS)) begin
            s = s - (PW + 1)'(SLOTS);
        end
        return s[PW-1:0];
    endfunction

    assign rd_off    = i_rd_data[crb_pkg::OFF_W-1:0];
    assign rd_len    = i_rd_data[crb_pkg::TAG_LSB-1:crb_pkg::LEN_LSB];
    assign new_entry = {r_tag, r_len, r_off};
    assign tail      = ptr_add(r_base, r_cnt);
    assign last_slot = ptr_dec(tail);
    assign out_free  = !r_out_vld || !i_stall;
    assign head_match = (rd_off == r_pos);
    assign shift_up   = (rd_off > r_off);
    // full table: the head after insertion is the arrival only if it sorts first
    assign full_drop  = (((r_off < rd_off) ? r_off : rd_off) != r_pos);

    assign o_stall           = (r_state != crb_pkg::S_IDLE);
    assign o_valid           = r_out_vld;
    assign o_released_offset = r_out_off;
    assign o_released_length = r_out_len;
    assign o_released_tag    = r_out_tag;
    assign o_dropped         = r_out_drop;
    assign o_last            = r_out_last;

    always_comb begin
        n_state = r_state;
        case (r_state)
            crb_pkg::S_IDLE: begin
                if (i_valid) begin
                    if (r_cnt == '0) begin
                        n_state = crb_pkg::S_PUT;
                    end else if (r_cnt == CW'(TABLE_DEPTH)) begin
                        n_state = crb_pkg::S_FULL_CHK;
                    end else begin
                        n_state = crb_pkg::S_SHIFT;
                    end
                end
            end
            crb_pkg::S_FULL_CHK: begin
                n_state = full_drop ? crb_pkg::S_DROP : crb_pkg::S_SHIFT;
            end
            crb_pkg::S_SHIFT: begin
                if (!shift_up) begin
                    n_state = crb_pkg::S_REL_RD;
                end else if (r_left == '0) begin
                    n_state = crb_pkg::S_PUT;
                end
            end
            crb_pkg::S_PUT: begin
                n_state = crb_pkg::S_REL_RD;
            end
            crb_pkg::S_REL_RD: begin
                n_state = crb_pkg::S_REL_CHK;
            end
            crb_pkg::S_REL_CHK: begin
                if (!head_match) begin
                    n_state = r_cand_vld ? crb_pkg::S_REL_END : crb_pkg::S_IDLE;
                end else if ((!r_cand_vld || out_free) && (r_cnt == CW'(1))) begin
                    n_state = crb_pkg::S_REL_END;
                end
            end
            crb_pkg::S_REL_END: begin
                if (out_free) begin
                    n_state = crb_pkg::S_IDLE;
                end
            end
            crb_pkg::S_DROP: begin
                if (out_free) begin
                    n_state = crb_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = crb_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_base     = r_base;
        n_cnt      = r_cnt;
        n_pos      = r_pos;
        n_ptr      = r_ptr;
        n_left     = r_left;
        n_off      = r_off;
        n_len      = r_len;
        n_tag      = r_tag;
        n_cand_vld = r_cand_vld;
        n_cand_off = r_cand_off;
        n_cand_len = r_cand_len;
        n_cand_tag = r_cand_tag;
        n_out_vld  = r_out_vld && i_stall;
        n_out_off  = r_out_off;
        n_out_len  = r_out_len;
        n_out_tag  = r_out_tag;
        n_out_drop = r_out_drop;
        n_out_last = r_out_last;
        o_mem_ctl  = '0;
        o_rd_addr  = r_base;
        o_wr_addr  = r_ptr;
        o_wr_data  = new_entry;
        case (r_state)
            crb_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_off      = i_chunk_offset;
                    n_len      = i_chunk_length;
                    n_tag      = i_chunk_tag;
                    n_cand_vld = 1'b0;
                    if (r_cnt == '0) begin
                        n_ptr = tail;
                    end else if (r_cnt == CW'(TABLE_DEPTH)) begin
                        o_mem_ctl.rd_en = 1'b1;
                        o_rd_addr       = r_base;
                    end else begin
                        o_mem_ctl.rd_en = 1'b1;
                        o_rd_addr       = last_slot;
                        n_ptr           = last_slot;
                        n_left          = PW'(r_cnt - CW'(1));
                    end
                end
            end
            crb_pkg::S_FULL_CHK: begin
                if (!full_drop) begin
                    o_mem_ctl.rd_en = 1'b1;
                    o_rd_addr       = last_slot;
                    n_ptr           = last_slot;
                    n_left          = PW'(TABLE_DEPTH - 1);
                end
            end
            crb_pkg::S_SHIFT: begin
                // walk down from the tail, moving larger offsets up one slot
                o_mem_ctl.wr_en = 1'b1;
                o_wr_addr       = ptr_inc(r_ptr);
                if (shift_up) begin
                    o_wr_data = i_rd_data;
                    if (r_left != '0) begin
                        o_mem_ctl.rd_en = 1'b1;
                        o_rd_addr       = ptr_dec(r_ptr);
                        n_ptr           = ptr_dec(r_ptr);
                        n_left          = r_left - 1'b1;
                    end
                end else begin
                    o_wr_data = new_entry;
                    n_cnt     = r_cnt + 1'b1;
                end
            end
            crb_pkg::S_PUT: begin
                o_mem_ctl.wr_en = 1'b1;
                o_wr_addr       = r_ptr;
                o_wr_data       = new_entry;
                n_cnt           = r_cnt + 1'b1;
            end
            crb_pkg::S_REL_RD: begin
                o_mem_ctl.rd_en = 1'b1;
                o_rd_addr       = r_base;
            end
            crb_pkg::S_REL_CHK: begin
                // hold one release back until the next head tells whether it is the last
                if (head_match && (!r_cand_vld || out_free)) begin
                    if (r_cand_vld) begin
                        n_out_vld  = 1'b1;
                        n_out_off  = r_cand_off;
                        n_out_len  = r_cand_len;
                        n_out_tag  = r_cand_tag;
                        n_out_drop = 1'b0;
                        n_out_last = 1'b0;
                    end
                    n_cand_vld = 1'b1;
                    n_cand_off = rd_off;
                    n_cand_len = rd_len;
                    n_cand_tag = i_rd_data[EW-1:crb_pkg::TAG_LSB];
                    n_base     = ptr_inc(r_base);
                    n_cnt      = r_cnt - 1'b1;
                    n_pos      = r_pos + crb_pkg::OFF_W'(rd_len);
                    if (r_cnt != CW'(1)) begin
                        o_mem_ctl.rd_en = 1'b1;
                        o_rd_addr       = ptr_inc(r_base);
                    end
                end
            end
            crb_pkg::S_REL_END: begin
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_off  = r_cand_off;
                    n_out_len  = r_cand_len;
                    n_out_tag  = r_cand_tag;
                    n_out_drop = 1'b0;
                    n_out_last = 1'b1;
                    n_cand_vld = 1'b0;
                end
            end
            crb_pkg::S_DROP: begin
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_off  = r_off;
                    n_out_len  = '0;
                    n_out_tag  = r_tag;
                    n_out_drop = 1'b1;
                    n_out_last = 1'b1;
                end
            end
            default: begin
                n_cand_vld = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= crb_pkg::S_IDLE;
            r_base     <= '0;
            r_cnt      <= '0;
            r_pos      <= '0;
            r_cand_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_base     <= n_base;
            r_cnt      <= n_cnt;
            r_pos      <= n_pos;
            r_cand_vld <= n_cand_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr      <= n_ptr;
        r_left     <= n_left;
        r_off      <= n_off;
        r_len      <= n_len;
        r_tag      <= n_tag;
        r_cand_off <= n_cand_off;
        r_cand_len <= n_cand_len;
        r_cand_tag <= n_cand_tag;
        r_out_off  <= n_out_off;
        r_out_len  <= n_out_len;
        r_out_tag  <= n_out_tag;
        r_out_drop <= n_out_drop;
        r_out_last <= n_out_last;
    end

    `CRB_ASSERT(a_cnt_idle, i_clk, i_rst_n, (r_state != crb_pkg::S_IDLE) || (r_cnt <= CW'(TABLE_DEPTH)), "pending count above table depth while idle")
    `CRB_ASSERT(a_base_range, i_clk, i_rst_n, r_base <= PW'(SLOTS - 1), "head pointer outside the table")
    `CRB_ASSERT_IMP(a_rw_apart, i_clk, i_rst_n, o_mem_ctl.rd_en && o_mem_ctl.wr_en, o_rd_addr != o_wr_addr, "table read and write hit the same slot")
    `CRB_ASSERT_IMP(a_drop_full, i_clk, i_rst_n, r_state == crb_pkg::S_DROP, r_cnt == CW'(TABLE_DEPTH), "drop taken with room in the table")
    `CRB_ASSERT_NXT(a_release_last, i_clk, i_rst_n, (r_state == crb_pkg::S_REL_END) && out_free, o_valid && o_last && !o_dropped, "final release not flagged as last")

endmodule

// ===== rtl/chunk_reorder_buffer.sv =====
// Top level of the chunk reorder buffer: pending table memory and its sequencer.
// One descriptor at a time: the input stalls while the sequencer is busy with an arrival;
//   the walk over the pending table does one read and one write per cycle.
// Reset: empties the table, clears the write position and drops any held result; the table
//   memory itself is not cleared, so there is no clearing pass.
module chunk_reorder_buffer #(
    parameter int TABLE_DEPTH = 16,
    parameter int TAG_BITS    = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [crb_pkg::OFF_W-1:0] i_chunk_offset,
    input  logic [crb_pkg::LEN_W-1:0] i_chunk_length,
    input  logic [TAG_BITS-1:0]       i_chunk_tag,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [crb_pkg::OFF_W-1:0] o_released_offset,
    output logic [crb_pkg::LEN_W-1:0] o_released_length,
    output logic [TAG_BITS-1:0]       o_released_tag,
    output logic                      o_dropped,
    output logic                      o_last
);

    // One spare slot lets an arrival join a full table before the release decides
    // whether it stays; the table is a ring with a moving head.
    localparam int SLOTS = TABLE_DEPTH + 1;
    localparam int PW    = $clog2(SLOTS);
    localparam int EW    = crb_pkg::TAG_LSB + TAG_BITS;

    crb_pkg::t_mem_ctl mem_ctl;
    logic [PW-1:0]     rd_addr;
    logic [PW-1:0]     wr_addr;
    logic [EW-1:0]     wr_data;
    logic [EW-1:0]     rd_data;

    // Entries hold offset, length and tag; the read data is registered and arrives in the cycle after its address.
    crb_table #(
        .SLOTS (SLOTS),
        .AW    (PW),
        .DW    (EW)
    ) u_table (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    // Sequencer: walk the table from the tail to sort the arrival in, then release
    // from the head while it matches the write position. A release is held back one
    // step so that the last transfer of each arrival can be flagged.
    crb_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .TAG_BITS    (TAG_BITS),
        .PW          (PW),
        .EW          (EW)
    ) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_chunk_offset    (i_chunk_offset),
        .i_chunk_length    (i_chunk_length),
        .i_chunk_tag       (i_chunk_tag),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_released_offset (o_released_offset),
        .o_released_length (o_released_length),
        .o_released_tag    (o_released_tag),
        .o_dropped         (o_dropped),
        .o_last            (o_last),
        .o_mem_ctl         (mem_ctl),
        .o_rd_addr         (rd_addr),
        .o_wr_addr         (wr_addr),
        .o_wr_data         (wr_data),
        .i_rd_data         (rd_data)
    );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the chunk reorder buffer against a resequencing predictor.
`timescale 1ns / 1ps

module tb_top;

    localparam int DEPTH = 16;    // pending table size of the instance
    localparam int TAG_W = 8;
    localparam int LIMIT = 5000;  // idle cycles before the watchdog gives up
    localparam int TAIL  = 64;    // extra wait after the last expected release

    typedef logic [crb_pkg::OFF_W-1:0] t_off;
    typedef logic [crb_pkg::LEN_W-1:0] t_len;
    typedef logic [TAG_W-1:0]          t_tag;

    typedef struct {
        t_off off;
        t_len len;
        t_tag tag;
    } t_chunk;

    typedef struct {
        t_off off;
        t_len len;
        t_tag tag;
        logic dropped;
        logic last;
    } t_release;

    logic i_clk          = 1'b0;
    logic i_rst_n        = 1'b0;
    logic i_valid        = 1'b0;
    logic i_stall        = 1'b0;
    t_off i_chunk_offset = '0;
    t_len i_chunk_length = '0;
    t_tag i_chunk_tag    = '0;
    logic o_stall;
    logic o_valid;
    t_off o_released_offset;
    t_len o_released_length;
    t_tag o_released_tag;
    logic o_dropped;
    logic o_last;

    chunk_reorder_buffer #(
        .TABLE_DEPTH (DEPTH),
        .TAG_BITS    (TAG_W)
    ) uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_chunk_offset    (i_chunk_offset),
        .i_chunk_length    (i_chunk_length),
        .i_chunk_tag       (i_chunk_tag),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_released_offset (o_released_offset),
        .o_released_length (o_released_length),
        .o_released_tag    (o_released_tag),
        .o_dropped         (o_dropped),
        .o_last            (o_last)
    );

    // Descriptors waiting to be driven, and releases waiting to be seen.
    t_chunk   chunk_q[$];
    t_release release_q[$];
    int       err_cnt = 0;

    // Predictor state: the pending table as a sorted prefix, and the write position.
    t_off held_off[DEPTH];
    t_len held_len[DEPTH];
    t_tag held_tag[DEPTH];
    int   held_cnt = 0;
    t_off next_pos = '0;

    // Stimulus planning: where the next well-formed run starts, and how many
    // far-away chunks sit in the table for good.
    t_off gen_pos = '0;
    int   far_cnt = 0;

    // Handshake bookkeeping for the monitor, driver and receiver; in_taken goes from monitor to driver.
    logic in_taken = 1'b0;
    int   burst_left = 0;
    int   gap_left = 0;
    int   stall_left = 0;
    int   free_left = 0;
    int   idle_cycles = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Sort the arrival in behind every pending chunk with an offset not above
    // its own, then release from the head while it starts at the position.
    // If the result would overflow the table, refuse the arrival instead and
    // leave the table and the position as they were.
    function automatic void resequence_chunk(t_off off, t_len len, t_tag tag);
        t_off     w_off[DEPTH+1];
        t_len     w_len[DEPTH+1];
        t_tag     w_tag[DEPTH+1];
        t_release run[$];
        t_release r;
        t_off     pos;
        int       ins;
        int       n;
        int       head;
        int       i;

        pos  = next_pos;
        ins  = 0;
        n    = 0;
        head = 0;
        while (ins < held_cnt && held_off[ins] <= off)
            ins++;
        for (i = 0; i < ins; i++) begin
            w_off[n] = held_off[i];
            w_len[n] = held_len[i];
            w_tag[n] = held_tag[i];
            n++;
        end
        w_off[n] = off;
        w_len[n] = len;
        w_tag[n] = tag;
        n++;
        for (i = ins; i < held_cnt; i++) begin
            w_off[n] = held_off[i];
            w_len[n] = held_len[i];
            w_tag[n] = held_tag[i];
            n++;
        end

        while (head < n && w_off[head] == pos) begin
            r.off     = w_off[head];
            r.len     = w_len[head];
            r.tag     = w_tag[head];
            r.dropped = 1'b0;
            r.last    = 1'b0;
            run.push_back(r);
            pos = pos + t_off'(w_len[head]);   // wraps modulo 2^32
            head++;
        end

        if (n - head > DEPTH) begin
            r.off     = off;
            r.len     = '0;
            r.tag     = tag;
            r.dropped = 1'b1;
            r.last    = 1'b1;
            release_q.push_back(r);
            return;
        end

        next_pos = pos;
        held_cnt = n - head;
        for (i = head; i < n; i++) begin
            held_off[i-head] = w_off[i];
            held_len[i-head] = w_len[i];
            held_tag[i-head] = w_tag[i];
        end
        if (run.size() > 0)
            run[run.size()-1].last = 1'b1;
        for (i = 0; i < run.size(); i++)
            release_q.push_back(run[i]);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_cnt++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus planning
    // ------------------------------------------------------------------

    function automatic void add_chunk(t_off off, t_len len, t_tag tag);
        t_chunk c;

        c.off = off;
        c.len = len;
        c.tag = tag;
        chunk_q.push_back(c);
    endfunction

    // Mostly short chunks; now and then zero, the nominal maximum, or anything
    // the field holds, oversize lengths included.
    function automatic t_len pick_length(bit allow_zero);
        t_len len;

        case ($urandom_range(0, 15))
            0:       len = '0;
            1:       len = t_len'($urandom_range(0, 4095));
            2:       len = t_len'(2048);
            default: len = t_len'($urandom_range(1, 64));
        endcase
        if (!allow_zero && len == '0)
            len = t_len'(1);
        return len;
    endfunction

    // Random descriptor that must not land on the given offset.
    function automatic void add_noise(t_off avoid);
        t_off off;

        off = $urandom;
        if (off == avoid)
            off[31] = ~off[31];
        add_chunk(off, t_len'($urandom_range(0, 4095)), t_tag'($urandom_range(0, 255)));
    endfunction

    // Plan a gap-free run of k chunks from gen_pos and send it, mostly out of order.
    // A zero-length chunk shares its offset with its successor, so hold it
    // ahead of that successor: otherwise the successor goes first and the
    // zero-length one is left stale at the head of the table.
    // A full run withholds the head chunk until the table is full, throws in
    // a few descriptors that must be refused, then sends the head to drain it.
    function automatic void add_run(int k, bit full);
        t_off c_off[DEPTH+1];
        t_len c_len[DEPTH+1];
        t_tag c_tag[DEPTH+1];
        int   order[DEPTH+1];
        int   rank[DEPTH+1];
        int   i;
        int   j;
        int   a;
        int   b;
        int   tmp;
        int   span;

        for (i = 0; i < k; i++) begin
            c_off[i] = gen_pos;
            c_len[i] = pick_length(!full && (i == 0 || c_len[i-1] != '0));
            c_tag[i] = t_tag'($urandom_range(0, 255));
            gen_pos  = gen_pos + t_off'(c_len[i]);
        end

        if (full) begin
            for (i = 0; i < k - 1; i++)
                order[i] = i + 1;
            order[k-1] = 0;
            span = k - 1;
        end else begin
            for (i = 0; i < k; i++)
                order[i] = i;
            span = ($urandom_range(0, 3) == 0) ? 0 : k;
        end
        for (i = span - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end

        for (i = 0; i < k; i++)
            rank[order[i]] = i;
        for (i = 0; i < k - 1; i++) begin
            if (c_len[i] == '0 && rank[i] > rank[i+1]) begin
                a          = rank[i];
                b          = rank[i+1];
                order[a]   = i + 1;
                order[b]   = i;
                rank[i]    = b;
                rank[i+1]  = a;
            end
        end

        for (i = 0; i < k; i++) begin
            if (full && i == k - 1)
                repeat ($urandom_range(1, 3)) add_noise(c_off[0]);
            add_chunk(c_off[order[i]], c_len[order[i]], c_tag[order[i]]);
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: check the result side first, then predict the input side, so
    // a result is never matched against an item taken at the same edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_release want;
        logic     in_fire;
        logic     out_fire;

        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_fire  = i_valid && !o_stall;
            out_fire = o_valid && !i_stall;

            if (out_fire) begin
                if (release_q.size() == 0) begin
                    $error("unexpected result: offset 0x%0h tag 0x%0h",
                           o_released_offset, o_released_tag);
                    err_cnt++;
                end else begin
                    want = release_q.pop_front();
                    check_field("released_offset", 32'(want.off), 32'(o_released_offset));
                    check_field("released_length", 32'(want.len), 32'(o_released_length));
                    check_field("released_tag", 32'(want.tag), 32'(o_released_tag));
                    check_field("dropped", 32'(want.dropped), 32'(o_dropped));
                    check_field("last", 32'(want.last), 32'(o_last));
                end
            end

            if (in_fire)
                resequence_chunk(i_chunk_offset, i_chunk_length, i_chunk_tag);
            in_taken <= in_fire;

            // Watchdog: give up once nothing has moved for too long.
            if (in_fire || out_fire) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= LIMIT) begin
                    $display("RESULT: ERROR");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: offer descriptors in bursts with random gaps; hold a stalled
    // transfer unchanged until it is taken.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : driver
        t_chunk item;

        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (chunk_q.size() > 0) begin
                item = chunk_q.pop_front();
                i_chunk_offset <= item.off;
                i_chunk_length <= item.len;
                i_chunk_tag    <= item.tag;
                i_valid        <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: alternate stall runs with free runs, now and then a long
    // stretch with no stall at all.
    always @(negedge i_clk) begin : receiver
        if (stall_left == 0 && free_left == 0) begin
            stall_left = $urandom_range(0, 6);
            free_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
        end
        if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            free_left--;
            i_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin : main
        int i;
        int pick;

        // In-order start, then a chunk that waits for its predecessor.
        add_chunk(32'd0, 12'd1, 8'h00);
        add_chunk(32'd3, 12'd2, 8'hFF);
        add_chunk(32'd1, 12'd2, 8'hAA);
        // Zero length at the position, then a chunk at the same offset.
        add_chunk(32'd5, 12'd0, 8'h01);
        // Oversize length, then the nominal maximum.
        add_chunk(32'd5, 12'd4095, 8'h55);
        add_chunk(32'd4100, 12'd2048, 8'h80);
        // Fill the table back to front, refuse two arrivals (one far above,
        // one below the position), then drain all seventeen at once.
        for (i = DEPTH; i >= 1; i--)
            add_chunk(32'd6148 + i, 12'd1, t_tag'($urandom_range(0, 255)));
        add_chunk(32'hFFFF_FFFF, 12'd4095, 8'hFF);
        add_chunk(32'd0, 12'd0, 8'h00);
        add_chunk(32'd6148, 12'd1, 8'h3C);
        gen_pos = 32'd6148 + DEPTH + 1;

        // Random part: mostly gap-free runs, some full-table drains, and a few
        // chunks far above the position that stay pending for good.
        while (chunk_q.size() < 380) begin
            pick = $urandom_range(0, 19);
            if (pick < 2 && far_cnt < 4) begin
                add_chunk($urandom | 32'h8000_0000, t_len'($urandom_range(0, 4095)),
                          t_tag'($urandom_range(0, 255)));
                far_cnt++;
            end else if (pick < 5) begin
                add_run(DEPTH + 1 - far_cnt, 1'b1);
            end else begin
                add_run($urandom_range(1, DEPTH + 1 - far_cnt), 1'b0);
            end
        end

        // Stale chunk last: it blocks every release from here on, so the
        // table fills and the rest is refused.
        add_chunk(gen_pos - 1, t_len'($urandom_range(1, 4095)), t_tag'($urandom_range(0, 255)));
        repeat (20) add_noise(gen_pos);

        repeat (10) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        while (chunk_q.size() != 0 || i_valid || release_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL) @(posedge i_clk);

        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
